// ----- src/rtu_pkg.sv -----
// Shared types, constants and the CRC step for the bus transaction engine.
package rtu_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_BYTE    = 2'd1,
    REQ_SUBMIT  = 2'd2,
    REQ_DISCARD = 2'd3
  } rtu_req_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND      = 3'd1,
    ACT_COMPLETED = 3'd2,
    ACT_FAILED    = 3'd3,
    ACT_DISCARDED = 3'd4,
    ACT_REJECTED  = 3'd5,
    ACT_STORE     = 3'd6,
    ACT_DROP      = 3'd7
  } rtu_act_e;

  // one queued query descriptor, 33 bits
  typedef struct packed {
    logic [3:0]  tag;
    logic [7:0]  len;
    logic [15:0] limit;
    logic [3:0]  attempts;
    logic        defer;
  } rtu_entry_t;

  typedef struct packed {
    rtu_act_e    act;
    logic [3:0]  tag;
    logic [8:0]  flen;
    logic [7:0]  sidx;
    logic [7:0]  sdata;
  } rtu_res_t;

  // divider request: numerator over (baud * 1000)
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [29:0] den;
  } rtu_div_req_t;

  localparam int unsigned BitsPerChar = 11;
  localparam logic [31:0] WireNum  = 32'(BitsPerChar * 1000000);
  localparam logic [31:0] GapNum   = 32'(BitsPerChar * 3500000);
  localparam logic [29:0] MsPerSec = 30'd1000;
  localparam logic [19:0] BaudReset = 20'd9600;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/rtu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/rtu_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module rtu_div
  import rtu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rtu_div_req_t req_i,
  output logic         done_o,
  output logic [31:0]  quo_o
);

  logic [29:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [29:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [30:0] trial;

  assign trial = {rem_q, quo_q[31]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in the next numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = 30'(trial - {1'b0, den_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[29:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/rtu_master_transaction_engine_core.sv -----
// Top level of the serial bus query transaction engine.
// Flow: a tick, submit, discard of an empty queue or received byte goes from start through
//   the execute state to the registered result strobe; a send also runs the serial divider;
//   a discard scan reads the RAM once per queued entry, in a scan and a compare state.
// Throughput: one word at a time; busy_o stays high until the result is shown, and for a
//   received byte until the silence gap has been computed.
// Reset: all control state clears at once, baud rate returns to 9600; the query RAM is not
//   cleared, since only written entries are ever read. The receiver cannot stall.
module rtu_master_transaction_engine_core
  import rtu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_FRAME   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        baud_we_i,
  input  logic [19:0] baud_wdata_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_data_i,
  input  logic [3:0]  query_tag_i,
  input  logic [7:0]  query_length_i,
  input  logic [15:0] response_limit_ms_i,
  input  logic [3:0]  attempts_i,
  input  logic        defer_retry_i,
  output logic        valid_o,
  output logic [2:0]  action_o,
  output logic [3:0]  tag_o,
  output logic [8:0]  frame_length_o,
  output logic [7:0]  store_index_o,
  output logic [7:0]  store_data_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_SCAN = 5'b01000,
    S_SCMP = 5'b10000
  } state_e;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : IW'(i + 1'b1);
  endfunction

  state_e      state_q, state_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, p_q, p_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d;
  logic        bus_q, bus_d, ovr_q, ovr_d, found_q, found_d, mode_q, mode_d;
  logic [8:0]  rc_q, rc_d;
  logic [15:0] crc_q, crc_d, st_q, st_d, marks_q, marks_d;
  logic [21:0] rt_q, rt_d;
  logic [19:0] baud_q;
  logic        vld_q, vld_d;
  rtu_res_t    res_q, res_d;

  // latched request word
  rtu_req_e    req_q, req_d;
  logic [7:0]  data_q, data_d;
  rtu_entry_t  ient_q, ient_d;
  rtu_entry_t  send_q, send_d;

  // query RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  rtu_entry_t    ram_wdata, ram_rdata;

  // divider
  rtu_div_req_t div_req;
  logic         div_done;
  logic [31:0]  div_quo;
  logic [19:0]  eff_baud;

  assign eff_baud = (baud_q == '0) ? 20'd1 : baud_q;
  assign busy_o   = (state_q != S_IDLE);
  assign ram_raddr = (state_q == S_SCAN) ? p_q : head_q;

  rtu_ram #(.WIDTH($bits(rtu_entry_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rtu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    rtu_entry_t  h;
    rtu_entry_t  e;
    logic [3:0]  att;
    logic [15:0] sdec;
    logic [21:0] rdec;
    logic        expired;
    logic        do_send;
    logic        do_retire;
    logic        do_retry;
    logic        f;

    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    bus_d   = bus_q;
    ovr_d   = ovr_q;
    rc_d    = rc_q;
    crc_d   = crc_q;
    st_d    = st_q;
    rt_d    = rt_q;
    marks_d = marks_q;
    p_d     = p_q;
    i_d     = i_q;
    found_d = found_q;
    mode_d  = mode_q;
    req_d   = req_q;
    data_d  = data_q;
    ient_d  = ient_q;
    send_d  = send_q;
    vld_d   = 1'b0;
    res_d   = res_q;

    ram_we    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = ient_q;

    div_req.start = 1'b0;
    div_req.num   = GapNum;
    div_req.den   = {10'd0, eff_baud} * MsPerSec;

    h         = ram_rdata;
    e         = ram_rdata;
    att       = '0;
    sdec      = '0;
    rdec      = '0;
    expired   = 1'b0;
    do_send   = 1'b0;
    do_retire = 1'b0;
    do_retry  = 1'b0;
    f         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // take the request word
          req_d  = rtu_req_e'(req_type_i);
          data_d = rx_data_i;
          ient_d = '{tag: query_tag_i, len: query_length_i, limit: response_limit_ms_i,
                     attempts: attempts_i, defer: defer_retry_i};
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        case (req_q)
          REQ_TICK: begin
            if (!bus_q) begin
              if (cnt_q == '0) begin
                vld_d = 1'b1;
                res_d = '{ACT_NONE, 4'd0, 9'd0, 8'd0, 8'd0};
              end else if (marks_q[h.tag]) begin
                do_retire = 1'b1;
              end else begin
                e       = h;
                do_send = 1'b1;
              end
            end else if (cnt_q == '0) begin
              bus_d = 1'b0;
              vld_d = 1'b1;
              res_d = '{ACT_NONE, 4'd0, 9'd0, 8'd0, 8'd0};
            end else begin
              if (rc_q != '0) begin
                sdec    = (st_q != '0) ? st_q - 16'd1 : st_q;
                st_d    = sdec;
                expired = (sdec == '0);
              end else begin
                rdec    = (rt_q != '0) ? rt_q - 22'd1 : rt_q;
                rt_d    = rdec;
                expired = (rdec == '0);
              end
              if (!expired) begin
                vld_d = 1'b1;
                res_d = '{ACT_NONE, 4'd0, 9'd0, 8'd0, 8'd0};
              end else if (marks_q[h.tag]) begin
                do_retire = 1'b1;
              end else if (rc_q != '0 && rc_q >= 9'd2 && crc_q == '0) begin
                // good frame: complete and free the bus
                head_d = nxt(head_q);
                cnt_d  = CW'(cnt_q - 1'b1);
                bus_d  = 1'b0;
                vld_d  = 1'b1;
                res_d  = '{ACT_COMPLETED, h.tag, 9'(rc_q - 9'd2), 8'd0, 8'd0};
              end else begin
                do_retry = 1'b1;
              end
            end
          end

          REQ_BYTE: begin
            if (!bus_q || cnt_q == '0) begin
              vld_d = 1'b1;
              res_d = '{ACT_DROP, 4'd0, 9'd0, 8'd0, 8'd0};
            end else begin
              if (!ovr_q && ({1'b0, rc_q} + 10'd1) <= 10'(MAX_FRAME)) begin
                vld_d = 1'b1;
                res_d = '{ACT_STORE, h.tag, 9'd0, rc_q[7:0], data_q};
                crc_d = crc16_byte(crc_q, data_q);
                rc_d  = rc_q + 9'd1;
              end else begin
                ovr_d = 1'b1;
                vld_d = 1'b1;
                res_d = '{ACT_DROP, h.tag, 9'd0, 8'd0, 8'd0};
              end
              // restart silence timing once the gap is known
              mode_d        = 1'b0;
              div_req.start = 1'b1;
              div_req.num   = GapNum;
              state_d       = S_DIV;
            end
          end

          REQ_SUBMIT: begin
            if (({1'b0, ient_q.len} + 9'd2) > 9'(MAX_FRAME) || cnt_q >= CW'(QUEUE_DEPTH)) begin
              vld_d = 1'b1;
              res_d = '{ACT_REJECTED, ient_q.tag, 9'd0, 8'd0, 8'd0};
            end else begin
              ram_we    = 1'b1;
              ram_waddr = tail_q;
              ram_wdata = ient_q;
              tail_d    = nxt(tail_q);
              cnt_d     = CW'(cnt_q + 1'b1);
              if (cnt_q == '0 && !bus_q) begin
                e       = ient_q;
                do_send = 1'b1;
              end else begin
                vld_d = 1'b1;
                res_d = '{ACT_NONE, ient_q.tag, 9'd0, 8'd0, 8'd0};
              end
            end
          end

          default: begin
            // discard: scan the queue for the tag
            if (cnt_q == '0) begin
              vld_d = 1'b1;
              res_d = '{ACT_DISCARDED, ient_q.tag, 9'd0, 8'd0, 8'd0};
            end else begin
              p_d     = head_q;
              i_d     = '0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
          end
        endcase

        if (do_retire) begin
          head_d = nxt(head_q);
          cnt_d  = CW'(cnt_q - 1'b1);
          marks_d[h.tag] = 1'b0;
          bus_d  = 1'b0;
          vld_d  = 1'b1;
          res_d  = '{ACT_DISCARDED, h.tag, 9'd0, 8'd0, 8'd0};
        end

        if (do_retry) begin
          att        = (h.attempts != '0) ? h.attempts - 4'd1 : 4'd0;
          e          = h;
          e.attempts = att;
          if (att != '0) begin
            if (e.defer && cnt_q > CW'(1)) begin
              // move to the tail, count stays
              head_d    = nxt(head_q);
              ram_we    = 1'b1;
              ram_waddr = tail_q;
              ram_wdata = e;
              tail_d    = nxt(tail_q);
              bus_d     = 1'b0;
              vld_d     = 1'b1;
              res_d     = '{ACT_NONE, e.tag, 9'd0, 8'd0, 8'd0};
            end else begin
              ram_we    = 1'b1;
              ram_waddr = head_q;
              ram_wdata = e;
              do_send   = 1'b1;
            end
          end else begin
            head_d = nxt(head_q);
            cnt_d  = CW'(cnt_q - 1'b1);
            bus_d  = 1'b0;
            vld_d  = 1'b1;
            res_d  = '{ACT_FAILED, e.tag, 9'd0, 8'd0, 8'd0};
          end
        end

        if (do_send) begin
          bus_d         = 1'b1;
          rc_d          = '0;
          ovr_d         = 1'b0;
          crc_d         = CrcInit;
          st_d          = '0;
          send_d        = e;
          mode_d        = 1'b1;
          div_req.start = 1'b1;
          div_req.num   = 32'({1'b0, e.len} + 9'd2) * WireNum;
          state_d       = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_d = S_IDLE;
          if (mode_q) begin
            rt_d  = 22'({6'd0, send_q.limit} + div_quo[21:0]);
            vld_d = 1'b1;
            res_d = '{ACT_SEND, send_q.tag, 9'({1'b0, send_q.len} + 9'd2), 8'd0, 8'd0};
          end else begin
            st_d = (div_quo == '0) ? 16'd1 : div_quo[15:0];
          end
        end
      end

      S_SCAN: begin
        state_d = S_SCMP;
      end

      S_SCMP: begin
        f = found_q | (ram_rdata.tag == ient_q.tag);
        if (CW'(i_q + 1'b1) == cnt_q) begin
          state_d = S_IDLE;
          vld_d   = 1'b1;
          if (f) begin
            marks_d[ient_q.tag] = 1'b1;
            res_d = '{ACT_NONE, ient_q.tag, 9'd0, 8'd0, 8'd0};
          end else begin
            res_d = '{ACT_DISCARDED, ient_q.tag, 9'd0, 8'd0, 8'd0};
          end
        end else begin
          i_d     = CW'(i_q + 1'b1);
          p_d     = nxt(p_q);
          found_d = f;
          state_d = S_SCAN;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      bus_q   <= 1'b0;
      ovr_q   <= 1'b0;
      rc_q    <= '0;
      crc_q   <= CrcInit;
      st_q    <= '0;
      rt_q    <= '0;
      marks_q <= '0;
      baud_q  <= BaudReset;
      vld_q   <= 1'b0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      bus_q   <= bus_d;
      ovr_q   <= ovr_d;
      rc_q    <= rc_d;
      crc_q   <= crc_d;
      st_q    <= st_d;
      rt_q    <= rt_d;
      marks_q <= marks_d;
      vld_q   <= vld_d;
      mode_q  <= mode_d;
      if (baud_we_i) begin
        baud_q <= baud_wdata_i;
      end
    end
  end

  // payload and scan registers need no reset
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    data_q  <= data_d;
    ient_q  <= ient_d;
    send_q  <= send_d;
    p_q     <= p_d;
    i_q     <= i_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  assign valid_o        = vld_q;
  assign action_o       = res_q.act;
  assign tag_o          = res_q.tag;
  assign frame_length_o = res_q.flen;
  assign store_index_o  = res_q.sidx;
  assign store_data_o   = res_q.sdata;

endmodule

// ----- src/rtu_chk.sv -----
// Port-level checker for the transaction engine, bound to the top level.
module rtu_chk
  import rtu_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [2:0]  action_o,
  input logic [8:0]  frame_length_o,
  input logic [7:0]  store_index_o,
  input logic [7:0]  store_data_o
);

  // an accepted word keeps the engine busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("engine idle right after accepting a word");

  // one result per word: strobes never come back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for two cycles");

  // a send always carries the two CRC bytes
  a_send_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && action_o == ACT_SEND) |-> (frame_length_o >= 9'd2))
    else $error("send length below CRC size");

  // store fields are zero unless a byte is stored
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && action_o != ACT_STORE) |-> (store_index_o == 8'd0 && store_data_o == 8'd0))
    else $error("store fields set on a non-store result");

endmodule

bind rtu_master_transaction_engine_core rtu_chk u_rtu_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .action_o       (action_o),
  .frame_length_o (frame_length_o),
  .store_index_o  (store_index_o),
  .store_data_o   (store_data_o)
);
